FILE: hw/rtl/i2cem_pkg.sv
// shared types and constants of the i2c eeprom master sequencer
// used by the step logic and the top level
package i2cem_pkg;

   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic CSR_DEVICE_ADDRESS    = 1'b0;
   localparam logic CSR_ACK_TIMEOUT_LIMIT = 1'b1;

   localparam logic [6:0] DEVICE_ADDRESS_RESET    = 7'd80;
   localparam logic [7:0] ACK_TIMEOUT_LIMIT_RESET = 8'd250;

   // byte_stage values
   localparam logic [2:0] STAGE_DEVICE   = 3'd0;
   localparam logic [2:0] STAGE_WORD     = 3'd1;
   localparam logic [2:0] STAGE_SECOND   = 3'd2;
   localparam logic [2:0] STAGE_THIRD    = 3'd3;
   localparam logic [2:0] STAGE_ABORT    = 3'd7;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [21:0] {
      PH_IDLE = 22'h000001,
      PH_ST0  = 22'h000002,
      PH_ST1  = 22'h000004,
      PH_ST2  = 22'h000008,
      PH_ST3  = 22'h000010,
      PH_TX0  = 22'h000020,
      PH_TX1  = 22'h000040,
      PH_TX2  = 22'h000080,
      PH_TX3  = 22'h000100,
      PH_AK0  = 22'h000200,
      PH_AK1  = 22'h000400,
      PH_AKW  = 22'h000800,
      PH_RX0  = 22'h001000,
      PH_RX1  = 22'h002000,
      PH_MA0  = 22'h004000,
      PH_MA1  = 22'h008000,
      PH_MA2  = 22'h010000,
      PH_MA3  = 22'h020000,
      PH_SP0  = 22'h040000,
      PH_SP1  = 22'h080000,
      PH_SP2  = 22'h100000,
      PH_SP3  = 22'h200000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] bit_index;
      logic [7:0] shift_byte;
      logic [7:0] wait_count;
      logic       is_read;
      logic [7:0] held_address;
      logic [7:0] held_first;
      logic [7:0] held_second;
      logic [7:0] bytes_left;
      logic [2:0] byte_stage;
      logic       scl_out;
      logic       sda_out;
   } state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] mem_address;
      logic [7:0] write_first;
      logic [7:0] write_second;
      logic [7:0] read_count;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic [6:0] device_address;
      logic [7:0] ack_timeout_limit;
   } cfg_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       read_last;
      logic       done_res;
      logic       nack_error;
      logic       busy_res;
      logic       command_rejected;
   } rsp_type;

endpackage

FILE: hw/rtl/i2cem_req_if.sv
// request channel of the i2c eeprom master sequencer: valid/ready plus item fields
// standalone, no package needed
interface i2cem_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] mem_address;
   logic [7:0] write_first;
   logic [7:0] write_second;
   logic [7:0] read_count;
   logic       sda_sample;

   modport source (
      output valid, opcode, mem_address, write_first, write_second, read_count, sda_sample,
      input  ready
   );
   modport sink (
      input  valid, opcode, mem_address, write_first, write_second, read_count, sda_sample,
      output ready
   );
endinterface

FILE: hw/rtl/i2cem_rsp_if.sv
// result channel of the i2c eeprom master sequencer: valid/ready plus result fields
// standalone, no package needed
interface i2cem_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic [7:0] read_byte;
   logic       read_valid;
   logic       read_last;
   logic       done_res;
   logic       nack_error;
   logic       busy_res;
   logic       command_rejected;

   modport source (
      output valid, scl_level, sda_level, read_byte, read_valid, read_last,
             done_res, nack_error, busy_res, command_rejected,
      input  ready
   );
   modport sink (
      input  valid, scl_level, sda_level, read_byte, read_valid, read_last,
             done_res, nack_error, busy_res, command_rejected,
      output ready
   );
endinterface

FILE: hw/rtl/i2cem_step.sv
// next-state and result logic for one item of the i2c sequencer
// depends on i2cem_pkg
module i2cem_step (
   input  i2cem_pkg::state_type state_cur,
   input  i2cem_pkg::req_type   req_item,
   input  i2cem_pkg::cfg_type   cfg,
   output i2cem_pkg::state_type state_nxt,
   output i2cem_pkg::rsp_type   result
);

   logic [2:0] stage_inc;
   logic [3:0] bit_inc;
   logic [7:0] rx_shift;
   logic [7:0] bytes_dec;

   assign stage_inc = state_cur.byte_stage + 3'd1;
   assign bit_inc   = state_cur.bit_index + 4'd1;
   assign rx_shift  = {state_cur.shift_byte[6:0], req_item.sda_sample};
   assign bytes_dec = state_cur.bytes_left - 8'd1;

   always_comb begin
      state_nxt = state_cur;
      result    = '0;

      if (req_item.opcode == i2cem_pkg::OP_WRITE || req_item.opcode == i2cem_pkg::OP_READ) begin
         if (state_cur.phase != i2cem_pkg::PH_IDLE) begin
            result.command_rejected = 1'b1;
         end else begin
            state_nxt.is_read      = (req_item.opcode == i2cem_pkg::OP_READ);
            state_nxt.held_address = req_item.mem_address;
            state_nxt.held_first   = req_item.write_first;
            state_nxt.held_second  = req_item.write_second;
            state_nxt.bytes_left   = req_item.read_count;
            state_nxt.byte_stage   = i2cem_pkg::STAGE_DEVICE;
            state_nxt.bit_index    = '0;
            state_nxt.shift_byte   = '0;
            state_nxt.wait_count   = '0;
            state_nxt.phase        = i2cem_pkg::PH_ST0;
         end
      end else if (req_item.opcode == i2cem_pkg::OP_TICK) begin
         case (state_cur.phase)
            i2cem_pkg::PH_IDLE: begin
               state_nxt.phase = i2cem_pkg::PH_IDLE;
            end
            i2cem_pkg::PH_ST0: begin
               state_nxt.scl_out = 1'b1;
               state_nxt.phase   = i2cem_pkg::PH_ST1;
            end
            i2cem_pkg::PH_ST1: begin
               state_nxt.sda_out = 1'b1;
               state_nxt.phase   = i2cem_pkg::PH_ST2;
            end
            i2cem_pkg::PH_ST2: begin
               state_nxt.sda_out = 1'b0;
               state_nxt.phase   = i2cem_pkg::PH_ST3;
            end
            i2cem_pkg::PH_ST3: begin
               // device address byte, read bit set only after the repeated start
               state_nxt.scl_out    = 1'b0;
               state_nxt.shift_byte = {cfg.device_address,
                                       state_cur.byte_stage == i2cem_pkg::STAGE_SECOND};
               state_nxt.bit_index  = '0;
               state_nxt.phase      = i2cem_pkg::PH_TX0;
            end
            i2cem_pkg::PH_TX0: begin
               state_nxt.scl_out = 1'b0;
               state_nxt.phase   = i2cem_pkg::PH_TX1;
            end
            i2cem_pkg::PH_TX1: begin
               state_nxt.sda_out = state_cur.shift_byte[7];
               state_nxt.phase   = i2cem_pkg::PH_TX2;
            end
            i2cem_pkg::PH_TX2: begin
               state_nxt.scl_out = 1'b1;
               state_nxt.phase   = i2cem_pkg::PH_TX3;
            end
            i2cem_pkg::PH_TX3: begin
               state_nxt.scl_out    = 1'b0;
               state_nxt.shift_byte = {state_cur.shift_byte[6:0], 1'b0};
               state_nxt.bit_index  = bit_inc;
               state_nxt.phase      = (bit_inc >= i2cem_pkg::BITS_PER_BYTE) ?
                                      i2cem_pkg::PH_AK0 : i2cem_pkg::PH_TX0;
            end
            i2cem_pkg::PH_AK0: begin
               state_nxt.sda_out    = 1'b1;
               state_nxt.wait_count = '0;
               state_nxt.phase      = i2cem_pkg::PH_AK1;
            end
            i2cem_pkg::PH_AK1: begin
               state_nxt.scl_out = 1'b1;
               state_nxt.phase   = i2cem_pkg::PH_AKW;
            end
            i2cem_pkg::PH_AKW: begin
               if (!req_item.sda_sample) begin
                  state_nxt.scl_out    = 1'b0;
                  state_nxt.wait_count = '0;
                  state_nxt.byte_stage = stage_inc;
                  // pick the next byte or bus condition after a good ack
                  if (stage_inc == i2cem_pkg::STAGE_WORD) begin
                     state_nxt.shift_byte = state_cur.held_address;
                     state_nxt.bit_index  = '0;
                     state_nxt.phase      = i2cem_pkg::PH_TX0;
                  end else if (state_cur.is_read) begin
                     if (stage_inc == i2cem_pkg::STAGE_SECOND) begin
                        state_nxt.phase = i2cem_pkg::PH_ST0;
                     end else if (state_cur.bytes_left != 8'd0) begin
                        state_nxt.shift_byte = '0;
                        state_nxt.bit_index  = '0;
                        state_nxt.phase      = i2cem_pkg::PH_RX0;
                     end else begin
                        state_nxt.phase = i2cem_pkg::PH_SP0;
                     end
                  end else if (stage_inc == i2cem_pkg::STAGE_SECOND) begin
                     state_nxt.shift_byte = state_cur.held_first;
                     state_nxt.bit_index  = '0;
                     state_nxt.phase      = i2cem_pkg::PH_TX0;
                  end else if (stage_inc == i2cem_pkg::STAGE_THIRD) begin
                     state_nxt.shift_byte = state_cur.held_second;
                     state_nxt.bit_index  = '0;
                     state_nxt.phase      = i2cem_pkg::PH_TX0;
                  end else begin
                     state_nxt.phase = i2cem_pkg::PH_SP0;
                  end
               end else if (state_cur.wait_count == cfg.ack_timeout_limit) begin
                  state_nxt.wait_count = '0;
                  state_nxt.byte_stage = i2cem_pkg::STAGE_ABORT;
                  state_nxt.phase      = i2cem_pkg::PH_SP0;
               end else begin
                  state_nxt.wait_count = state_cur.wait_count + 8'd1;
               end
            end
            i2cem_pkg::PH_RX0: begin
               state_nxt.scl_out = 1'b1;
               state_nxt.sda_out = 1'b1;
               state_nxt.phase   = i2cem_pkg::PH_RX1;
            end
            i2cem_pkg::PH_RX1: begin
               state_nxt.shift_byte = rx_shift;
               state_nxt.scl_out    = 1'b0;
               state_nxt.bit_index  = bit_inc;
               if (bit_inc >= i2cem_pkg::BITS_PER_BYTE) begin
                  result.read_valid = 1'b1;
                  result.read_byte  = rx_shift;
                  result.read_last  = (state_cur.bytes_left == 8'd1);
                  state_nxt.phase   = i2cem_pkg::PH_MA0;
               end else begin
                  state_nxt.phase = i2cem_pkg::PH_RX0;
               end
            end
            i2cem_pkg::PH_MA0: begin
               state_nxt.scl_out = 1'b0;
               state_nxt.phase   = i2cem_pkg::PH_MA1;
            end
            i2cem_pkg::PH_MA1: begin
               // nack the last byte, ack the others
               state_nxt.sda_out = (state_cur.bytes_left == 8'd1);
               state_nxt.phase   = i2cem_pkg::PH_MA2;
            end
            i2cem_pkg::PH_MA2: begin
               state_nxt.scl_out = 1'b1;
               state_nxt.phase   = i2cem_pkg::PH_MA3;
            end
            i2cem_pkg::PH_MA3: begin
               state_nxt.scl_out    = 1'b0;
               state_nxt.bytes_left = bytes_dec;
               if (bytes_dec == 8'd0) begin
                  state_nxt.phase = i2cem_pkg::PH_SP0;
               end else begin
                  state_nxt.shift_byte = '0;
                  state_nxt.bit_index  = '0;
                  state_nxt.phase      = i2cem_pkg::PH_RX0;
               end
            end
            i2cem_pkg::PH_SP0: begin
               state_nxt.scl_out = 1'b0;
               state_nxt.phase   = i2cem_pkg::PH_SP1;
            end
            i2cem_pkg::PH_SP1: begin
               state_nxt.sda_out = 1'b0;
               state_nxt.phase   = i2cem_pkg::PH_SP2;
            end
            i2cem_pkg::PH_SP2: begin
               state_nxt.scl_out = 1'b1;
               state_nxt.phase   = i2cem_pkg::PH_SP3;
            end
            i2cem_pkg::PH_SP3: begin
               state_nxt.sda_out = 1'b1;
               result.done_res   = 1'b1;
               result.nack_error = (state_cur.byte_stage == i2cem_pkg::STAGE_ABORT);
               state_nxt.phase   = i2cem_pkg::PH_IDLE;
            end
            default: begin
               state_nxt.phase = i2cem_pkg::PH_IDLE;
            end
         endcase
      end

      result.scl_level = state_nxt.scl_out;
      result.sda_level = state_nxt.sda_out;
      result.busy_res  = (state_nxt.phase != i2cem_pkg::PH_IDLE);
   end

endmodule

FILE: hw/rtl/i2c_eeprom_master_sequencer_core.sv
// top level of the i2c eeprom master sequencer: sequencer state, config and result register
// depends on i2cem_pkg, i2cem_req_if, i2cem_rsp_if and i2cem_step
//
// Usage:
//   req_chan carries items: a write command (word address, two data bytes), a read
//   command (word address, byte count) or a tick with the sampled SDA level. Each
//   tick steps one bus phase, or waits for an ack. rsp_chan returns exactly one result per
//   item: the SCL/SDA drive after that step plus read byte, done, nack and busy flags.
//   csr_write_en/csr_index/csr_write_data set the device address (index 0) and the
//   ack timeout (index 1); write them only while no transaction runs.
//   The result of an item is registered onto rsp_chan in the cycle after it is accepted.
//   Throughput: one item per cycle; the sequencer state is updated in the cycle of
//   acceptance and the result goes into a single output register.
//   When rsp_chan stalls, that register holds its result and req_chan.ready drops
//   until it is taken; it rises again in the same cycle the result leaves.
//   Reset: bus lines released high, sequencer idle, device address 80, timeout 250,
//   result register empty.
module i2c_eeprom_master_sequencer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   i2cem_req_if.sink                             req_chan,
   i2cem_rsp_if.source                           rsp_chan,
   input  logic                                  csr_write_en,
   input  logic                                  csr_index,
   input  logic [i2cem_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   i2cem_pkg::state_type state_ff, state_in, state_step;
   i2cem_pkg::cfg_type   cfg_ff, cfg_in;
   i2cem_pkg::rsp_type   rsp_ff, rsp_in, rsp_step;
   i2cem_pkg::req_type   req_item;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_fire;

   assign req_item.opcode       = req_chan.opcode;
   assign req_item.mem_address  = req_chan.mem_address;
   assign req_item.write_first  = req_chan.write_first;
   assign req_item.write_second = req_chan.write_second;
   assign req_item.read_count   = req_chan.read_count;
   assign req_item.sda_sample   = req_chan.sda_sample;

   i2cem_step u_step (
      .state_cur (state_ff),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .state_nxt (state_step),
      .result    (rsp_step)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (req_fire) begin
         state_in     = state_step;
         rsp_in       = rsp_step;
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            i2cem_pkg::CSR_DEVICE_ADDRESS:    cfg_in.device_address    = csr_write_data[6:0];
            i2cem_pkg::CSR_ACK_TIMEOUT_LIMIT: cfg_in.ack_timeout_limit = csr_write_data[7:0];
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{phase:        i2cem_pkg::PH_IDLE,
                           bit_index:    4'd0,
                           shift_byte:   8'd0,
                           wait_count:   8'd0,
                           is_read:      1'b0,
                           held_address: 8'd0,
                           held_first:   8'd0,
                           held_second:  8'd0,
                           bytes_left:   8'd0,
                           byte_stage:   i2cem_pkg::STAGE_DEVICE,
                           scl_out:      1'b1,
                           sda_out:      1'b1};
         cfg_ff       <= '{device_address:    i2cem_pkg::DEVICE_ADDRESS_RESET,
                           ack_timeout_limit: i2cem_pkg::ACK_TIMEOUT_LIMIT_RESET};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.scl_level        = rsp_ff.scl_level;
   assign rsp_chan.sda_level        = rsp_ff.sda_level;
   assign rsp_chan.read_byte        = rsp_ff.read_byte;
   assign rsp_chan.read_valid       = rsp_ff.read_valid;
   assign rsp_chan.read_last        = rsp_ff.read_last;
   assign rsp_chan.done_res         = rsp_ff.done_res;
   assign rsp_chan.nack_error       = rsp_ff.nack_error;
   assign rsp_chan.busy_res         = rsp_ff.busy_res;
   assign rsp_chan.command_rejected = rsp_ff.command_rejected;

   // start accepted while idle always opens with the start condition
   a_start_enters_st0 : assert property (@(posedge clock) disable iff (reset)
      req_fire && state_ff.phase == i2cem_pkg::PH_IDLE &&
      (req_chan.opcode == i2cem_pkg::OP_WRITE || req_chan.opcode == i2cem_pkg::OP_READ)
      |=> state_ff.phase == i2cem_pkg::PH_ST0)
      else $error("start command did not enter start phase");

   // busy flag of the result tracks the sequencer state left by the item
   a_busy_matches_state : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff &&
                   rsp_ff.busy_res == (state_ff.phase != i2cem_pkg::PH_IDLE))
      else $error("busy flag disagrees with sequencer phase");

   // a nack report only comes with the stop that ends the transaction
   a_nack_with_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.nack_error |-> rsp_ff.done_res && !rsp_ff.busy_res)
      else $error("nack reported without completed stop");

endmodule

FILE: verif/i2c_eeprom_master_sequencer_core_tb.sv
// self-checking testbench of the i2c eeprom master sequencer: an eeprom-side responder
// drives the ticks, a bus-level predictor works out every result, a checker compares them
// depends on i2cem_pkg, i2cem_req_if, i2cem_rsp_if and i2c_eeprom_master_sequencer_core
`timescale 1ns / 100ps

module i2c_eeprom_master_sequencer_core_tb;

   localparam logic [1:0] OP_NOOP = 2'd3;
   localparam int RANDOM_ITEMS = 600;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_index;
   logic [i2cem_pkg::CSR_DATA_W-1:0] csr_write_data;

   i2cem_req_if req_chan();
   i2cem_rsp_if rsp_chan();

   i2c_eeprom_master_sequencer_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // bus sequencer model
   i2cem_pkg::phase_type ph;
   logic [3:0] bit_idx;
   logic [7:0] shreg;
   logic [7:0] wait_cnt;
   logic       rd_mode;
   logic [7:0] hold_addr;
   logic [7:0] hold_d0;
   logic [7:0] hold_d1;
   logic [7:0] left;
   logic [2:0] stage;
   logic       scl_q;
   logic       sda_q;
   logic [6:0] dev_addr;
   logic [7:0] ack_limit;

   i2cem_pkg::rsp_type bus_results_q[$];
   int      item_count;
   int      mismatch_count;

   // eeprom responder and idling controls
   int ack_window;
   int ack_hold;
   int nack_window;
   bit req_gaps_on;
   bit rsp_stalls_on;
   int rsp_hold_left;
   int rsp_stall_left;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic i2cem_pkg::req_type random_item();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[$bits(i2cem_pkg::req_type)-1:0];
   endfunction

   function automatic void load_byte(logic [7:0] value);
      shreg = value;
      bit_idx = 4'd0;
      ph = i2cem_pkg::PH_TX0;
   endfunction

   function automatic void start_receive();
      shreg = 8'd0;
      bit_idx = 4'd0;
      ph = i2cem_pkg::PH_RX0;
   endfunction

   // what follows a good ack depends on which byte was just acknowledged
   function automatic void advance_after_ack();
      stage = stage + 3'd1;
      if (rd_mode) begin
         if (stage == i2cem_pkg::STAGE_WORD) load_byte(hold_addr);
         else if (stage == i2cem_pkg::STAGE_SECOND) ph = i2cem_pkg::PH_ST0;
         else if (left != 8'd0) start_receive();
         else ph = i2cem_pkg::PH_SP0;
      end else begin
         if (stage == i2cem_pkg::STAGE_WORD) load_byte(hold_addr);
         else if (stage == i2cem_pkg::STAGE_SECOND) load_byte(hold_d0);
         else if (stage == i2cem_pkg::STAGE_THIRD) load_byte(hold_d1);
         else ph = i2cem_pkg::PH_SP0;
      end
   endfunction

   function automatic i2cem_pkg::rsp_type predict_bus_step(i2cem_pkg::req_type it);
      i2cem_pkg::rsp_type r;
      r = '0;
      if (it.opcode == i2cem_pkg::OP_WRITE || it.opcode == i2cem_pkg::OP_READ) begin
         if (ph != i2cem_pkg::PH_IDLE) begin
            r.command_rejected = 1'b1;
         end else begin
            rd_mode = (it.opcode == i2cem_pkg::OP_READ);
            hold_addr = it.mem_address;
            hold_d0 = it.write_first;
            hold_d1 = it.write_second;
            left = it.read_count;
            stage = i2cem_pkg::STAGE_DEVICE;
            bit_idx = 4'd0;
            shreg = 8'd0;
            wait_cnt = 8'd0;
            ph = i2cem_pkg::PH_ST0;
         end
      end else if (it.opcode == i2cem_pkg::OP_TICK) begin
         case (ph)
            i2cem_pkg::PH_ST0: begin scl_q = 1'b1; ph = i2cem_pkg::PH_ST1; end
            i2cem_pkg::PH_ST1: begin sda_q = 1'b1; ph = i2cem_pkg::PH_ST2; end
            i2cem_pkg::PH_ST2: begin sda_q = 1'b0; ph = i2cem_pkg::PH_ST3; end
            i2cem_pkg::PH_ST3: begin
               scl_q = 1'b0;
               load_byte({dev_addr, stage == i2cem_pkg::STAGE_SECOND});
            end
            i2cem_pkg::PH_TX0: begin scl_q = 1'b0; ph = i2cem_pkg::PH_TX1; end
            i2cem_pkg::PH_TX1: begin sda_q = shreg[7]; ph = i2cem_pkg::PH_TX2; end
            i2cem_pkg::PH_TX2: begin scl_q = 1'b1; ph = i2cem_pkg::PH_TX3; end
            i2cem_pkg::PH_TX3: begin
               scl_q = 1'b0;
               shreg = {shreg[6:0], 1'b0};
               bit_idx = bit_idx + 4'd1;
               ph = (bit_idx >= i2cem_pkg::BITS_PER_BYTE) ? i2cem_pkg::PH_AK0 :
                                                            i2cem_pkg::PH_TX0;
            end
            i2cem_pkg::PH_AK0: begin
               sda_q = 1'b1;
               wait_cnt = 8'd0;
               ph = i2cem_pkg::PH_AK1;
            end
            i2cem_pkg::PH_AK1: begin scl_q = 1'b1; ph = i2cem_pkg::PH_AKW; end
            i2cem_pkg::PH_AKW: begin
               if (!it.sda_sample) begin
                  scl_q = 1'b0;
                  wait_cnt = 8'd0;
                  advance_after_ack();
               end else if (wait_cnt == ack_limit) begin
                  wait_cnt = 8'd0;
                  stage = i2cem_pkg::STAGE_ABORT;
                  ph = i2cem_pkg::PH_SP0;
               end else begin
                  wait_cnt = wait_cnt + 8'd1;
               end
            end
            i2cem_pkg::PH_RX0: begin scl_q = 1'b1; sda_q = 1'b1; ph = i2cem_pkg::PH_RX1; end
            i2cem_pkg::PH_RX1: begin
               shreg = {shreg[6:0], it.sda_sample};
               scl_q = 1'b0;
               bit_idx = bit_idx + 4'd1;
               if (bit_idx >= i2cem_pkg::BITS_PER_BYTE) begin
                  r.read_valid = 1'b1;
                  r.read_byte = shreg;
                  r.read_last = (left == 8'd1);
                  ph = i2cem_pkg::PH_MA0;
               end else begin
                  ph = i2cem_pkg::PH_RX0;
               end
            end
            i2cem_pkg::PH_MA0: begin scl_q = 1'b0; ph = i2cem_pkg::PH_MA1; end
            // nack the last byte, ack the others
            i2cem_pkg::PH_MA1: begin sda_q = (left == 8'd1); ph = i2cem_pkg::PH_MA2; end
            i2cem_pkg::PH_MA2: begin scl_q = 1'b1; ph = i2cem_pkg::PH_MA3; end
            i2cem_pkg::PH_MA3: begin
               scl_q = 1'b0;
               left = left - 8'd1;
               if (left == 8'd0) ph = i2cem_pkg::PH_SP0;
               else start_receive();
            end
            i2cem_pkg::PH_SP0: begin scl_q = 1'b0; ph = i2cem_pkg::PH_SP1; end
            i2cem_pkg::PH_SP1: begin sda_q = 1'b0; ph = i2cem_pkg::PH_SP2; end
            i2cem_pkg::PH_SP2: begin scl_q = 1'b1; ph = i2cem_pkg::PH_SP3; end
            i2cem_pkg::PH_SP3: begin
               sda_q = 1'b1;
               r.done_res = 1'b1;
               r.nack_error = (stage == i2cem_pkg::STAGE_ABORT);
               ph = i2cem_pkg::PH_IDLE;
            end
            default: ph = i2cem_pkg::PH_IDLE;
         endcase
      end
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.busy_res = (ph != i2cem_pkg::PH_IDLE);
      return r;
   endfunction

   // eeprom side: acks after a short random wait, except in the window chosen to time out
   function automatic logic slave_sda();
      int r;
      logic level;
      if (ph == i2cem_pkg::PH_AKW) begin
         if (ack_hold < 0) begin
            if (ack_window == nack_window) begin
               ack_hold = 1000;
            end else begin
               r = $urandom_range(0, 99);
               ack_hold = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(4, 12);
            end
            ack_window++;
         end
         level = (ack_hold != 0);
         if (ack_hold > 0) ack_hold--;
      end else begin
         ack_hold = -1;
         level = 1'($urandom_range(0, 1));
      end
      return level;
   endfunction

   task automatic offer_item(input i2cem_pkg::req_type it);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid        <= 1'b1;
      req_chan.opcode       <= it.opcode;
      req_chan.mem_address  <= it.mem_address;
      req_chan.write_first  <= it.write_first;
      req_chan.write_second <= it.write_second;
      req_chan.read_count   <= it.read_count;
      req_chan.sda_sample   <= it.sda_sample;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bus_results_q.push_back(predict_bus_step(it));
      item_count++;
   endtask

   // stop offering and wait until every result has come back
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (bus_results_q.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [7:0] data);
      drain();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == i2cem_pkg::CSR_DEVICE_ADDRESS) dev_addr = data[6:0];
      else ack_limit = data;
   endtask

   task automatic offer_tick(input logic level);
      i2cem_pkg::req_type it;
      it = random_item();
      it.opcode = i2cem_pkg::OP_TICK;
      it.sda_sample = level;
      offer_item(it);
   endtask

   // one command and the ticks that carry it to its stop; noise items are busy
   // commands and no-ops slipped in between
   task automatic run_transaction(input bit rd, input logic [7:0] addr, input logic [7:0] d0,
                                  input logic [7:0] d1, input logic [7:0] cnt,
                                  input int nack_at, input int noise_pct);
      i2cem_pkg::req_type it;
      it = random_item();
      it.opcode = rd ? i2cem_pkg::OP_READ : i2cem_pkg::OP_WRITE;
      it.mem_address = addr;
      it.write_first = d0;
      it.write_second = d1;
      it.read_count = cnt;
      ack_window = 0;
      ack_hold = -1;
      nack_window = nack_at;
      offer_item(it);
      while (ph != i2cem_pkg::PH_IDLE) begin
         it = random_item();
         if ($urandom_range(0, 99) < noise_pct) begin
            if (it.opcode == i2cem_pkg::OP_TICK) it.opcode = OP_NOOP;
         end else begin
            it.opcode = i2cem_pkg::OP_TICK;
            it.sda_sample = slave_sda();
         end
         offer_item(it);
      end
   endtask

   task automatic test_idle_bus();
      i2cem_pkg::req_type it;
      offer_tick(1'b0);
      offer_tick(1'b1);
      it = random_item();
      it.opcode = OP_NOOP;
      offer_item(it);
      offer_tick(1'b0);
   endtask

   task automatic test_write_extremes();
      run_transaction(1'b0, 8'h00, 8'hFF, 8'h00, 8'h00, -1, 0);
      run_transaction(1'b0, 8'hFF, 8'h00, 8'hFF, 8'hFF, -1, 10);
   endtask

   task automatic test_read_lengths();
      run_transaction(1'b1, 8'h5A, 8'h00, 8'h00, 8'd0, -1, 0);
      run_transaction(1'b1, 8'hA5, 8'hFF, 8'hFF, 8'd1, -1, 0);
      run_transaction(1'b1, 8'h3C, 8'h12, 8'h34, 8'd3, -1, 10);
   endtask

   // a timeout in every ack window of a write, then in the repeated-start window of a read
   task automatic test_ack_timeouts();
      write_register(i2cem_pkg::CSR_ACK_TIMEOUT_LIMIT, 8'd3);
      for (int w = 0; w < 4; w++) begin
         run_transaction(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'd0, w, 0);
      end
      run_transaction(1'b1, 8'($urandom_range(0, 255)), 8'h00, 8'h00, 8'd2, 2, 5);
   endtask

   task automatic test_register_extremes();
      write_register(i2cem_pkg::CSR_DEVICE_ADDRESS, 8'h80);   // top bit is not part of the address
      run_transaction(1'b0, 8'h11, 8'h22, 8'h33, 8'd0, -1, 0);
      write_register(i2cem_pkg::CSR_DEVICE_ADDRESS, 8'h7F);
      run_transaction(1'b1, 8'h44, 8'h00, 8'h00, 8'd2, -1, 0);
      write_register(i2cem_pkg::CSR_ACK_TIMEOUT_LIMIT, 8'd255);
      run_transaction(1'b0, 8'h55, 8'h66, 8'h77, 8'd0, 0, 0);
      write_register(i2cem_pkg::CSR_ACK_TIMEOUT_LIMIT, 8'd0);
      run_transaction(1'b0, 8'h88, 8'h99, 8'hAA, 8'd0, -1, 0);
      run_transaction(1'b1, 8'hBB, 8'h00, 8'h00, 8'd1, 1, 0);
      write_register(i2cem_pkg::CSR_DEVICE_ADDRESS, {1'b0, i2cem_pkg::DEVICE_ADDRESS_RESET});
      write_register(i2cem_pkg::CSR_ACK_TIMEOUT_LIMIT, i2cem_pkg::ACK_TIMEOUT_LIMIT_RESET);
   endtask

   task automatic test_backpressure();
      req_gaps_on = 1'b0;
      rsp_hold_left = 300;
      run_transaction(1'b1, 8'($urandom_range(0, 255)), 8'h00, 8'h00, 8'd4, -1, 5);
      drain();
      req_gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int first;
      int r;
      int nack_at;
      logic [7:0] cnt;
      first = item_count;
      while (item_count - first < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            write_register(i2cem_pkg::CSR_DEVICE_ADDRESS, 8'($urandom_range(0, 255)));
         end else if (r < 12) begin
            r = $urandom_range(0, 99);
            write_register(i2cem_pkg::CSR_ACK_TIMEOUT_LIMIT,
                           8'((r < 60) ? $urandom_range(8, 40) :
                              (r < 85) ? $urandom_range(0, 3) : $urandom_range(41, 255)));
         end else if (r < 17) begin
            offer_tick(1'($urandom_range(0, 1)));
         end else if (r < 25) begin
            drain();
         end
         req_gaps_on = ($urandom_range(0, 4) != 0);
         rsp_stalls_on = ($urandom_range(0, 4) != 0);
         cnt = 8'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 4) : $urandom_range(5, 20));
         nack_at = ($urandom_range(0, 3) != 0) ? -1 : $urandom_range(0, 4);
         run_transaction(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cnt,
                         nack_at, $urandom_range(0, 2) * 5);
      end
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   task automatic test_longest_read();
      write_register(i2cem_pkg::CSR_ACK_TIMEOUT_LIMIT, 8'd20);
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      run_transaction(1'b1, 8'($urandom_range(0, 255)), 8'h00, 8'h00, 8'd24, -1, 0);
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // receiver: random stalls, plus a long hold-off when a test asks for one
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (rsp_stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (rsp_stalls_on && $urandom_range(0, 2) == 0) rsp_stall_left <= pick_gap();
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      i2cem_pkg::rsp_type got;
      i2cem_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.scl_level        = rsp_chan.scl_level;
         got.sda_level        = rsp_chan.sda_level;
         got.read_byte        = rsp_chan.read_byte;
         got.read_valid       = rsp_chan.read_valid;
         got.read_last        = rsp_chan.read_last;
         got.done_res         = rsp_chan.done_res;
         got.nack_error       = rsp_chan.nack_error;
         got.busy_res         = rsp_chan.busy_res;
         got.command_rejected = rsp_chan.command_rejected;
         if (bus_results_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result item %p", got);
         end else begin
            want = bus_results_q.pop_front();
            check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
            check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
            check_field("read_byte", want.read_byte, got.read_byte);
            check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
            check_field("read_last", 8'(want.read_last), 8'(got.read_last));
            check_field("done_res", 8'(want.done_res), 8'(got.done_res));
            check_field("nack_error", 8'(want.nack_error), 8'(got.nack_error));
            check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            check_field("command_rejected", 8'(want.command_rejected),
                        8'(got.command_rejected));
         end
      end
   end

   initial begin
      #30ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = i2cem_pkg::CSR_DEVICE_ADDRESS;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.opcode = i2cem_pkg::OP_TICK;
      req_chan.mem_address = 8'd0;
      req_chan.write_first = 8'd0;
      req_chan.write_second = 8'd0;
      req_chan.read_count = 8'd0;
      req_chan.sda_sample = 1'b1;
      rsp_chan.ready = 1'b0;
      rsp_hold_left = 0;
      rsp_stall_left = 0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      item_count = 0;
      mismatch_count = 0;
      ph = i2cem_pkg::PH_IDLE;
      bit_idx = 4'd0;
      shreg = 8'd0;
      wait_cnt = 8'd0;
      rd_mode = 1'b0;
      hold_addr = 8'd0;
      hold_d0 = 8'd0;
      hold_d1 = 8'd0;
      left = 8'd0;
      stage = i2cem_pkg::STAGE_DEVICE;
      scl_q = 1'b1;
      sda_q = 1'b1;
      dev_addr = i2cem_pkg::DEVICE_ADDRESS_RESET;
      ack_limit = i2cem_pkg::ACK_TIMEOUT_LIMIT_RESET;
      ack_window = 0;
      ack_hold = -1;
      nack_window = -1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_idle_bus();
      test_write_extremes();
      test_read_lengths();
      test_ack_timeouts();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      test_longest_read();

      drain();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/i2cem_pkg.sv
hw/rtl/i2cem_req_if.sv
hw/rtl/i2cem_rsp_if.sv
hw/rtl/i2cem_step.sv
hw/rtl/i2c_eeprom_master_sequencer_core.sv
verif/i2c_eeprom_master_sequencer_core_tb.sv
